FILE: src/slis_pkg.sv
// ----------------------------------------------------------------------------
// slis_pkg - shared types and constants
// Request codes, status codes and the result record of the sequential list.
// ----------------------------------------------------------------------------
package slis_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int KEY_W     = 16;
    localparam int AGE_W     = 8;
    localparam int POS_W     = 5;
    localparam int CNT_W     = 5;
    localparam int ENTRY_W   = KEY_W + AGE_W;

    typedef enum logic [1:0] {
        F_APPEND = 2'd0,
        F_INSERT = 2'd1,
        F_FIND   = 2'd2,
        F_CLEAR  = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2,
        ST_NOKEY = 2'd3
    } t_status;

    typedef struct packed {
        t_status             status;
        logic [POS_W-1:0]    found_position;
        logic [AGE_W-1:0]    found_age;
        logic [CNT_W-1:0]    count;
    } t_result;

endpackage

FILE: src/slis_mem.sv
// ----------------------------------------------------------------------------
// slis_mem - entry store
// Single write port, single registered read port; holds key and age pairs.
// ----------------------------------------------------------------------------
module slis_mem #(
    parameter int  DEPTH = slis_pkg::DEPTH_DEF,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                         i_clk,
    input  logic                         i_we,
    input  logic [AW-1:0]                i_waddr,
    input  logic [slis_pkg::ENTRY_W-1:0] i_wdata,
    input  logic                         i_re,
    input  logic [AW-1:0]                i_raddr,
    output logic [slis_pkg::ENTRY_W-1:0] o_rdata
);

    logic [slis_pkg::ENTRY_W-1:0] r_mem [DEPTH];
    logic [slis_pkg::ENTRY_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/slis_ctrl.sv
// ----------------------------------------------------------------------------
// slis_ctrl - list sequencer
// Decodes a request, walks the store for insert shifts and key scans, and
// holds the result until the output side takes it.
// ----------------------------------------------------------------------------
module slis_ctrl #(
    parameter int  DEPTH = slis_pkg::DEPTH_DEF,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW    = $clog2(DEPTH + 1)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_req_valid,
    output logic                         o_req_ready,
    input  logic [1:0]                   i_func,
    input  logic [slis_pkg::KEY_W-1:0]   i_key,
    input  logic [slis_pkg::AGE_W-1:0]   i_age,
    input  logic [slis_pkg::POS_W-1:0]   i_pos,
    output logic                         o_mem_we,
    output logic [AW-1:0]                o_mem_waddr,
    output logic [slis_pkg::ENTRY_W-1:0] o_mem_wdata,
    output logic                         o_mem_re,
    output logic [AW-1:0]                o_mem_raddr,
    input  logic [slis_pkg::ENTRY_W-1:0] i_mem_rdata,
    output logic                         o_res_valid,
    input  logic                         i_res_ready,
    output slis_pkg::t_result            o_res
);

    localparam int EW = (CW > slis_pkg::POS_W) ? CW : slis_pkg::POS_W;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SHIFT = 4'b0010,
        S_FIND  = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    t_state                        r_state, n_state;
    logic [CW-1:0]                 r_count, n_count;
    logic [slis_pkg::KEY_W-1:0]    r_key, n_key;
    logic [slis_pkg::AGE_W-1:0]    r_age, n_age;
    logic [AW-1:0]                 r_pos, n_pos;
    logic [AW-1:0]                 r_idx, n_idx;
    slis_pkg::t_result             r_res, n_res;

    logic [EW-1:0]                 w_pos_ext;
    logic [EW-1:0]                 w_cnt_ext;
    logic                          w_full;
    logic [slis_pkg::KEY_W-1:0]    w_rd_key;
    logic [slis_pkg::AGE_W-1:0]    w_rd_age;

    function automatic slis_pkg::t_result f_res(
        slis_pkg::t_status            st,
        logic [EW-1:0]                p,
        logic [slis_pkg::AGE_W-1:0]   a,
        logic [CW-1:0]                c
    );
        slis_pkg::t_result res;
        res.status         = st;
        res.found_position = slis_pkg::POS_W'(p);
        res.found_age      = a;
        res.count          = slis_pkg::CNT_W'(c);
        return res;
    endfunction

    assign w_pos_ext = EW'(i_pos);
    assign w_cnt_ext = EW'(r_count);
    assign w_full    = (r_count >= CW'(DEPTH));
    assign w_rd_key  = i_mem_rdata[slis_pkg::ENTRY_W-1 -: slis_pkg::KEY_W];
    assign w_rd_age  = i_mem_rdata[slis_pkg::AGE_W-1:0];

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_key       = r_key;
        n_age       = r_age;
        n_pos       = r_pos;
        n_idx       = r_idx;
        n_res       = r_res;
        o_mem_we    = 1'b0;
        o_mem_waddr = '0;
        o_mem_wdata = {r_key, r_age};
        o_mem_re    = 1'b0;
        o_mem_raddr = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_key   = i_key;
                    n_age   = i_age;
                    n_pos   = AW'(w_pos_ext);
                    n_state = S_DONE;
                    unique case (slis_pkg::t_func'(i_func))
                        slis_pkg::F_APPEND: begin
                            if (w_full) begin
                                n_res = f_res(slis_pkg::ST_FULL, '0, '0, r_count);
                            end else begin
                                o_mem_we    = 1'b1;
                                o_mem_waddr = AW'(r_count);
                                o_mem_wdata = {i_key, i_age};
                                n_count     = r_count + CW'(1);
                                n_res       = f_res(slis_pkg::ST_OK, w_cnt_ext, '0,
                                                    r_count + CW'(1));
                            end
                        end
                        slis_pkg::F_INSERT: begin
                            if (w_full) begin
                                n_res = f_res(slis_pkg::ST_FULL, '0, '0, r_count);
                            end else if (w_pos_ext > w_cnt_ext) begin
                                n_res = f_res(slis_pkg::ST_RANGE, '0, '0, r_count);
                            end else if (w_pos_ext == w_cnt_ext) begin
                                o_mem_we    = 1'b1;
                                o_mem_waddr = AW'(r_count);
                                o_mem_wdata = {i_key, i_age};
                                n_count     = r_count + CW'(1);
                                n_res       = f_res(slis_pkg::ST_OK, w_cnt_ext, '0,
                                                    r_count + CW'(1));
                            end else begin
                                o_mem_re    = 1'b1;
                                o_mem_raddr = AW'(r_count - CW'(1));
                                n_idx       = AW'(r_count);
                                n_state     = S_SHIFT;
                            end
                        end
                        slis_pkg::F_FIND: begin
                            if (r_count == '0) begin
                                n_res = f_res(slis_pkg::ST_NOKEY, '0, '0, r_count);
                            end else begin
                                o_mem_re    = 1'b1;
                                o_mem_raddr = '0;
                                n_idx       = '0;
                                n_state     = S_FIND;
                            end
                        end
                        slis_pkg::F_CLEAR: begin
                            n_count = '0;
                            n_res   = f_res(slis_pkg::ST_OK, '0, '0, '0);
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_SHIFT: begin
                o_mem_we = 1'b1;
                if (r_idx == r_pos) begin
                    o_mem_waddr = r_pos;
                    o_mem_wdata = {r_key, r_age};
                    n_count     = r_count + CW'(1);
                    n_res       = f_res(slis_pkg::ST_OK, EW'(r_pos), '0,
                                        r_count + CW'(1));
                    n_state     = S_DONE;
                end else begin
                    o_mem_waddr = r_idx;
                    o_mem_wdata = i_mem_rdata;
                    o_mem_re    = ((r_idx - AW'(1)) != r_pos);
                    o_mem_raddr = r_idx - AW'(2);
                    n_idx       = r_idx - AW'(1);
                end
            end
            S_FIND: begin
                if (w_rd_key == r_key) begin
                    n_res   = f_res(slis_pkg::ST_OK, EW'(r_idx), w_rd_age, r_count);
                    n_state = S_DONE;
                end else if ((CW'(r_idx) + CW'(1)) == r_count) begin
                    n_res   = f_res(slis_pkg::ST_NOKEY, '0, '0, r_count);
                    n_state = S_DONE;
                end else begin
                    o_mem_re    = 1'b1;
                    o_mem_raddr = r_idx + AW'(1);
                    n_idx       = r_idx + AW'(1);
                end
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
        r_key <= n_key;
        r_age <= n_age;
        r_pos <= n_pos;
        r_idx <= n_idx;
        r_res <= n_res;
    end

    assign o_req_ready = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_res       = r_res;

endmodule

FILE: src/sequential_list_insert_search.sv
// Requests are handled one at a time. Insert at a position below the count
//   shifts the entries from that position up by one place before writing;
//   find reads the entries in order from position 0 to the first match or the
//   last entry. The output register lets the next request in while a result
//   waits. Reset clears the entry count; the store is not cleared.
// ----------------------------------------------------------------------------
// sequential_list_insert_search - bounded gap-free key/age list
// Append, insert with shift, first-match key search and clear over one
// synchronous entry store, with a registered result stage.
// ----------------------------------------------------------------------------
module sequential_list_insert_search #(
    parameter int DEPTH = slis_pkg::DEPTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [1:0]                 i_func,
    input  logic [slis_pkg::KEY_W-1:0] i_entry_key,
    input  logic [slis_pkg::AGE_W-1:0] i_entry_age,
    input  logic [slis_pkg::POS_W-1:0] i_position,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [1:0]                 o_status,
    output logic [slis_pkg::POS_W-1:0] o_found_position,
    output logic [slis_pkg::AGE_W-1:0] o_found_age,
    output logic [slis_pkg::CNT_W-1:0] o_count
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic                         w_mem_we;
    logic [AW-1:0]                w_mem_waddr;
    logic [slis_pkg::ENTRY_W-1:0] w_mem_wdata;
    logic                         w_mem_re;
    logic [AW-1:0]                w_mem_raddr;
    logic [slis_pkg::ENTRY_W-1:0] w_mem_rdata;
    logic                         w_res_valid;
    logic                         w_res_ready;
    slis_pkg::t_result            w_res;

    logic                         r_out_valid;
    slis_pkg::t_result            r_out;

    slis_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_in_valid),
        .o_req_ready (o_in_ready),
        .i_func      (i_func),
        .i_key       (i_entry_key),
        .i_age       (i_entry_age),
        .i_pos       (i_position),
        .o_mem_we    (w_mem_we),
        .o_mem_waddr (w_mem_waddr),
        .o_mem_wdata (w_mem_wdata),
        .o_mem_re    (w_mem_re),
        .o_mem_raddr (w_mem_raddr),
        .i_mem_rdata (w_mem_rdata),
        .o_res_valid (w_res_valid),
        .i_res_ready (w_res_ready),
        .o_res       (w_res)
    );

    slis_mem #(
        .DEPTH (DEPTH)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_re    (w_mem_re),
        .i_raddr (w_mem_raddr),
        .o_rdata (w_mem_rdata)
    );

    assign w_res_ready = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_ready) begin
            r_out_valid <= w_res_valid;
        end
        if (w_res_valid && w_res_ready) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_out.status;
    assign o_found_position = r_out.found_position;
    assign o_found_age      = r_out.found_age;
    assign o_count          = r_out.count;

`ifndef SYNTH
    a_refused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != slis_pkg::ST_OK) |->
            (o_found_position == '0) && (o_found_age == '0))
        else $error("refused request reports a position or age");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == slis_pkg::ST_FULL) |->
            (o_count == slis_pkg::CNT_W'(DEPTH)))
        else $error("full status with list not at capacity");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_valid && !w_res_ready |=> w_res_valid && $stable(w_res))
        else $error("pending result dropped or changed while output stalled");
`endif

endmodule
